// ----- rtl/core/icmp_pkg.sv -----
// ----------------------------------------------------------------------------
// icmp_pkg
// Shared types, codes and helpers of the inline color markup parser.
// ----------------------------------------------------------------------------
package icmp_pkg;

  localparam logic [7:0]  CHAR_HASH  = 8'h23;
  localparam logic [7:0]  CHAR_BAR   = 8'h7C;
  localparam logic [23:0] DFLT_COLOR = 24'hFFFFFF;

  // scan modes of the markup tracker
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_HASH  = 2'd1;
  localparam logic [1:0] MODE_BAR   = 2'd2;
  localparam logic [1:0] MODE_COLOR = 2'd3;

  localparam int HELD_DEPTH = 5;
  localparam int SEQ_DEPTH  = HELD_DEPTH + 1;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       char_valid;
    logic       out_last;
  } out_item_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FEED_IN,
    OP_FEED_HELD,
    OP_HEAD,
    OP_WALK,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register can take a result this cycle
    logic feed_done;  // incoming byte consumed without a re-feed
    logic item_last;  // incoming request closes the message
    logic held_last;  // re-fed byte closes the message
    logic head_walk;  // held '#|' sequence must be rescanned
    logic walk_done;  // rescan ends with this step
  } dp_sts_t;

  // hex digit value, anything else reads as zero
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

endpackage

// ----- rtl/core/inline_color_markup_parser_unit.sv -----
// ----------------------------------------------------------------------------
// inline_color_markup_parser_unit
// Strips '#|RRGGBB' and '|#' color markup from a byte stream and tags each
// visible character with its current color.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------
//  in      | in_valid_i/in_ready_o  | in_item_i   (in_char, in_last)
//  out     | out_valid_o/out_ready_i| out_item_o  (char, rgb, flags)
//  cfg     | cfg_we_i               | cfg_wdata_i (default_color)
//
// Ordinary byte: taken straight from the port into the output register.
// A byte following a '#' or '|' that starts no markup is re-fed once.
// Last byte of a message: followed by a flush head step and a final result step,
// with up to 6 rescan steps between them when the message ends inside '#|'.
// Reset clears all control state; default color comes up as white.
// Every step waits while the output register holds an unaccepted request.
// ----------------------------------------------------------------------------
module inline_color_markup_parser_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  icmp_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output icmp_pkg::out_item_t out_item_o,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i
);
  import icmp_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  icmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  icmp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- rtl/core/icmp_ctrl.sv -----
// ----------------------------------------------------------------------------
// icmp_ctrl
// Sequencer: feeds each byte, re-feeds a byte after a broken markup start,
// then runs the end-of-message flush and the final result.
// ----------------------------------------------------------------------------
module icmp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  icmp_pkg::dp_sts_t   sts_i,
  output icmp_pkg::ctrl_cmd_t cmd_o
);
  import icmp_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REFEED = 3'd1;
  localparam logic [2:0] ST_HEAD   = 3'd2;
  localparam logic [2:0] ST_WALK   = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          cmd_o.op = OP_FEED_IN;
          if (!sts_i.feed_done) begin
            state_d = ST_REFEED;
          end else if (sts_i.item_last) begin
            state_d = ST_HEAD;
          end
        end
      end
      ST_REFEED: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FEED_HELD;
          state_d  = sts_i.held_last ? ST_HEAD : ST_IDLE;
        end
      end
      ST_HEAD: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_HEAD;
          state_d  = sts_i.head_walk ? ST_WALK : ST_FIN;
        end
      end
      ST_WALK: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_WALK;
          if (sts_i.walk_done) begin
            state_d = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.op = OP_FIN;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/core/icmp_datapath.sv -----
// ----------------------------------------------------------------------------
// icmp_datapath
// Markup tracker, held digits, flush rescan buffer, last-result holding
// register and output register.
// ----------------------------------------------------------------------------
module icmp_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  icmp_pkg::in_item_t  in_item_i,
  input  logic                cfg_we_i,
  input  logic [23:0]         cfg_wdata_i,
  input  icmp_pkg::ctrl_cmd_t cmd_i,
  output icmp_pkg::dp_sts_t   sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output icmp_pkg::out_item_t out_item_o
);
  import icmp_pkg::*;

  logic [23:0] dflt_q, cur_q, cur_d;
  logic [1:0]  mode_q, mode_d;
  logic [2:0]  digits_q, digits_d;
  logic        in_msg_q, in_msg_d;
  logic [7:0]  held_q [HELD_DEPTH];
  logic        held_we;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [7:0]  seq_q [SEQ_DEPTH];
  logic [7:0]  seq_d [SEQ_DEPTH];
  logic        seq_we;
  logic [2:0]  seq_len_q, seq_len_d;
  logic        hold_valid_q, hold_valid_d;
  logic [31:0] hold_q, hold_d;  // char and color of the newest last-message result
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        feed_op, step_in, emit, route_hold, pair;
  logic [7:0]  src, emit_char;
  logic [23:0] color_now;

  assign step_in    = (cmd_i.op == OP_FEED_IN);
  assign feed_op    = step_in || (cmd_i.op == OP_FEED_HELD);
  assign src        = step_in ? in_item_i.in_char : byte_q;
  assign color_now  = (step_in && !in_msg_q) ? dflt_q : cur_q;
  assign route_hold = step_in ? in_item_i.in_last : last_q;
  assign pair       = (seq_q[0] == CHAR_BAR) && (seq_len_q >= 3'd2) && (seq_q[1] == CHAR_HASH);

  // status comes from registers and the input port only, never from the command
  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.feed_done = !((mode_q == MODE_HASH && in_item_i.in_char != CHAR_BAR) ||
                             (mode_q == MODE_BAR && in_item_i.in_char != CHAR_HASH));
  assign sts_o.item_last = in_item_i.in_last;
  assign sts_o.held_last = last_q;
  assign sts_o.head_walk = (mode_q == MODE_COLOR);
  assign sts_o.walk_done = pair ? (seq_len_q == 3'd2) : (seq_len_q == 3'd1);

  always_comb begin
    cur_d        = color_now;
    mode_d       = mode_q;
    digits_d     = digits_q;
    in_msg_d     = in_msg_q;
    held_we      = 1'b0;
    seq_we       = 1'b0;
    seq_d        = seq_q;
    seq_len_d    = seq_len_q;
    emit         = 1'b0;
    emit_char    = src;
    hold_valid_d = hold_valid_q;
    hold_d       = hold_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    unique case (cmd_i.op)
      OP_FEED_IN, OP_FEED_HELD: begin
        unique case (mode_q)
          MODE_IDLE: begin
            if (src == CHAR_HASH) begin
              mode_d = MODE_HASH;
            end else if (src == CHAR_BAR) begin
              mode_d = MODE_BAR;
            end else begin
              emit = 1'b1;
            end
          end
          MODE_HASH: begin
            if (src == CHAR_BAR) begin
              mode_d   = MODE_COLOR;
              digits_d = 3'd0;
            end else begin
              emit      = 1'b1;
              emit_char = CHAR_HASH;
              mode_d    = MODE_IDLE;
            end
          end
          MODE_BAR: begin
            mode_d = MODE_IDLE;
            if (src == CHAR_HASH) begin
              cur_d = dflt_q;
            end else begin
              emit      = 1'b1;
              emit_char = CHAR_BAR;
            end
          end
          default: begin
            if (digits_q < 3'(HELD_DEPTH)) begin
              held_we  = 1'b1;
              digits_d = digits_q + 3'd1;
            end else begin
              cur_d    = {hex_nibble(held_q[0]), hex_nibble(held_q[1]),
                          hex_nibble(held_q[2]), hex_nibble(held_q[3]),
                          hex_nibble(held_q[4]), hex_nibble(src)};
              mode_d   = MODE_IDLE;
              digits_d = 3'd0;
            end
          end
        endcase
        if (step_in) begin
          in_msg_d = 1'b1;
        end
      end
      OP_HEAD: begin
        unique case (mode_q)
          MODE_IDLE: ;
          MODE_HASH: begin
            emit      = 1'b1;
            emit_char = CHAR_HASH;
          end
          MODE_BAR: begin
            emit      = 1'b1;
            emit_char = CHAR_BAR;
          end
          default: begin
            emit      = 1'b1;
            emit_char = CHAR_HASH;
            seq_we    = 1'b1;
            seq_d[0]  = CHAR_BAR;
            for (int k = 0; k < HELD_DEPTH; k++) begin
              seq_d[k+1] = held_q[k];
            end
            seq_len_d = digits_q + 3'd1;
          end
        endcase
        mode_d   = MODE_IDLE;
        digits_d = 3'd0;
      end
      OP_WALK: begin
        seq_we = 1'b1;
        if (pair) begin
          cur_d = dflt_q;
          for (int k = 0; k < SEQ_DEPTH - 2; k++) begin
            seq_d[k] = seq_q[k+2];
          end
          seq_len_d = seq_len_q - 3'd2;
        end else begin
          emit      = 1'b1;
          emit_char = seq_q[0];
          for (int k = 0; k < SEQ_DEPTH - 1; k++) begin
            seq_d[k] = seq_q[k+1];
          end
          seq_len_d = seq_len_q - 3'd1;
        end
      end
      OP_FIN: begin
        out_valid_d = 1'b1;
        if (hold_valid_q) begin
          out_d = {hold_q, 1'b1, 1'b1};
        end else begin
          out_d = '0;
          out_d.out_last = 1'b1;
        end
        hold_valid_d = 1'b0;
        in_msg_d     = 1'b0;
        cur_d        = dflt_q;
      end
      default: ;
    endcase

    if (emit) begin
      if (route_hold) begin
        // last message results wait in the hold register so the final one can be flagged
        if (hold_valid_q) begin
          out_d       = {hold_q, 1'b1, 1'b0};
          out_valid_d = 1'b1;
        end
        hold_d       = {emit_char, color_now};
        hold_valid_d = 1'b1;
      end else begin
        out_d       = {emit_char, color_now, 1'b1, 1'b0};
        out_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dflt_q       <= DFLT_COLOR;
      cur_q        <= DFLT_COLOR;
      mode_q       <= MODE_IDLE;
      digits_q     <= 3'd0;
      in_msg_q     <= 1'b0;
      seq_len_q    <= 3'd0;
      hold_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
      cur_q        <= cur_d;
      mode_q       <= mode_d;
      digits_q     <= digits_d;
      in_msg_q     <= in_msg_d;
      seq_len_q    <= seq_len_d;
      hold_valid_q <= hold_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_we && feed_op) begin
      held_q[digits_q] <= src;
    end
    if (seq_we) begin
      seq_q <= seq_d;
    end
    if (step_in) begin
      byte_q <= in_item_i.in_char;
      last_q <= in_item_i.in_last;
    end
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/core/icmp_checker.sv -----
// ----------------------------------------------------------------------------
// icmp_checker
// Port-level checks of the markup parser, bound to the top level.
// ----------------------------------------------------------------------------
module icmp_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input icmp_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input icmp_pkg::out_item_t out_item_o,
  input logic                cfg_we_i,
  input logic [23:0]         cfg_wdata_i
);

  // a result without a character only closes a message
  a_bare_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.char_valid |-> out_item_o.out_last)
    else $error("bare result without end flag");

  a_bare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.char_valid |->
      out_item_o.out_char == 8'd0 && out_item_o.red == 8'd0 &&
      out_item_o.green == 8'd0 && out_item_o.blue == 8'd0)
    else $error("bare result carries data");

  // end of message always runs the flush before the next request is taken
  a_flush_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_item_i.in_last |=> !in_ready_o)
    else $error("request taken during end-of-message flush");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

endmodule

bind inline_color_markup_parser_unit icmp_checker u_icmp_checker (.*);

// ----- tb/tb_inline_color_markup_parser_unit.sv -----
// ----------------------------------------------------------------------------
// tb_inline_color_markup_parser_unit
// Self-checking bench for the color markup parser. A behavioral predictor
// tracks color, scan state and held digits for every accepted byte and queues
// the colored glyphs it expects. A scoreboard process compares each accepted
// result field by field. Directed messages cover the edge cases, then random
// messages run under four sender and receiver pressure phases.
// ----------------------------------------------------------------------------
module tb_inline_color_markup_parser_unit;
  import icmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int MAX_GAP        = 24;
  localparam int MAX_RES        = 7;
  localparam int PHASE_ITEMS    = 125;
  localparam logic [7:0] LC_HEX_BIAS = 8'h61 - 8'd10;  // 'a' - 10
  localparam logic [7:0] UC_HEX_BIAS = 8'h41 - 8'd10;  // 'A' - 10

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_item_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i    = 1'b0;
  logic [23:0] cfg_wdata_i = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  inline_color_markup_parser_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // predictor state
  logic [23:0] dflt_rgb = DFLT_COLOR;
  logic [23:0] cur_rgb  = DFLT_COLOR;
  logic [1:0]  scan_st  = MODE_IDLE;
  int          n_digits = 0;
  logic [7:0]  digit_buf [HELD_DEPTH];
  bit          in_msg   = 1'b0;

  out_item_t   glyph_q [$];
  out_item_t   step_out [MAX_RES];
  int          n_step;
  out_item_t   want_glyph;
  logic [7:0]  msg_q [$];
  string       hex_chars = "0123456789abcdefABCDEF";

  int n_errors      = 0;
  int n_items       = 0;
  int n_glyphs      = 0;
  int n_msgs        = 0;
  int n_bare        = 0;
  int n_cfg         = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int quiet_cycles  = 0;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= "0" && c <= "9") d = c - "0";
    else if (c >= "a" && c <= "f") d = c - LC_HEX_BIAS;
    else if (c >= "A" && c <= "F") d = c - UC_HEX_BIAS;
    return d[3:0];
  endfunction

  task automatic emit_char(input logic [7:0] ch);
    out_item_t g;
    if (n_step < MAX_RES) begin
      g.out_char   = ch;
      g.red        = cur_rgb[23:16];
      g.green      = cur_rgb[15:8];
      g.blue       = cur_rgb[7:0];
      g.char_valid = 1'b1;
      g.out_last   = 1'b0;
      step_out[n_step] = g;
      n_step++;
    end
  endtask

  // a byte that breaks a pending marker is scanned again from idle
  task automatic scan_byte(input logic [7:0] c);
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      case (scan_st)
        MODE_IDLE: begin
          if (c == CHAR_HASH) scan_st = MODE_HASH;
          else if (c == CHAR_BAR) scan_st = MODE_BAR;
          else emit_char(c);
        end
        MODE_HASH: begin
          if (c == CHAR_BAR) begin
            scan_st  = MODE_COLOR;
            n_digits = 0;
          end else begin
            emit_char(CHAR_HASH);
            scan_st = MODE_IDLE;
            again   = 1'b1;
          end
        end
        MODE_BAR: begin
          if (c == CHAR_HASH) begin
            cur_rgb = dflt_rgb;
            scan_st = MODE_IDLE;
          end else begin
            emit_char(CHAR_BAR);
            scan_st = MODE_IDLE;
            again   = 1'b1;
          end
        end
        default: begin
          if (n_digits < HELD_DEPTH) begin
            digit_buf[n_digits] = c;
            n_digits++;
          end else begin
            cur_rgb = {digit_value(digit_buf[0]), digit_value(digit_buf[1]),
                       digit_value(digit_buf[2]), digit_value(digit_buf[3]),
                       digit_value(digit_buf[4]), digit_value(c)};
            scan_st  = MODE_IDLE;
            n_digits = 0;
          end
        end
      endcase
    end
  endtask

  // end of message: '#' goes out as is, the rest of '#|...' is rescanned
  task automatic flush_held();
    logic [7:0] seq [SEQ_DEPTH];
    int len;
    int i;
    case (scan_st)
      MODE_HASH: emit_char(CHAR_HASH);
      MODE_BAR:  emit_char(CHAR_BAR);
      MODE_COLOR: begin
        seq[0] = CHAR_BAR;
        len = 1;
        for (i = 0; i < n_digits; i++) begin
          seq[len] = digit_buf[i];
          len++;
        end
        emit_char(CHAR_HASH);
        i = 0;
        while (i < len) begin
          if (seq[i] == CHAR_BAR && i + 1 < len && seq[i + 1] == CHAR_HASH) begin
            cur_rgb = dflt_rgb;
            i += 2;
          end else begin
            emit_char(seq[i]);
            i++;
          end
        end
      end
      default: ;
    endcase
    scan_st  = MODE_IDLE;
    n_digits = 0;
  endtask

  task automatic predict_glyphs(input in_item_t it);
    int k;
    n_step = 0;
    if (!in_msg) begin
      cur_rgb = dflt_rgb;
      in_msg  = 1'b1;
    end
    scan_byte(it.in_char);
    if (it.in_last) begin
      flush_held();
      if (n_step == 0) begin
        step_out[0] = '0;
        n_step = 1;
        n_bare++;
      end
      step_out[n_step - 1].out_last = 1'b1;
      in_msg  = 1'b0;
      cur_rgb = dflt_rgb;
      n_msgs++;
    end
    for (k = 0; k < n_step; k++) glyph_q.push_back(step_out[k]);
  endtask

  task automatic send_item(input logic [7:0] c, input logic last);
    in_item_t it;
    int gap;
    it.in_char = c;
    it.in_last = last;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    predict_glyphs(it);
    n_items++;
  endtask

  task automatic send_text(input string s, input bit close);
    int i;
    for (i = 0; i < s.len(); i++) send_item(s[i], close && (i == s.len() - 1));
  endtask

  // block drained and quiet, safe for a register write
  task automatic settle();
    in_valid_i <= 1'b0;
    while (glyph_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_default(input logic [23:0] rgb);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= rgb;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    dflt_rgb = rgb;
    n_cfg++;
  endtask

  function automatic logic [7:0] digit_byte();
    if ($urandom_range(99) < 80) return hex_chars[$urandom_range(hex_chars.len() - 1)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] tail_byte();
    int r;
    r = $urandom_range(99);
    if (r < 30) return CHAR_HASH;
    if (r < 60) return CHAR_BAR;
    return digit_byte();
  endfunction

  task automatic build_message();
    int pieces;
    int p;
    int k;
    int kind;
    msg_q.delete();
    pieces = $urandom_range(4, 1);
    for (p = 0; p < pieces; p++) begin
      kind = $urandom_range(99);
      if (kind < 35) begin
        msg_q.push_back(8'($urandom_range(255)));
      end else if (kind < 60) begin
        msg_q.push_back(CHAR_HASH);
        msg_q.push_back(CHAR_BAR);
        for (k = 0; k < 6; k++) msg_q.push_back(digit_byte());
      end else if (kind < 72) begin
        msg_q.push_back(CHAR_BAR);
        msg_q.push_back(CHAR_HASH);
      end else if (kind < 80) begin
        msg_q.push_back(CHAR_HASH);
        msg_q.push_back(8'($urandom_range(255)));
      end else if (kind < 88) begin
        msg_q.push_back(CHAR_BAR);
      end else begin
        msg_q.push_back(tail_byte());
      end
    end
    // unfinished color markup at the end of the message
    if ($urandom_range(99) < 20) begin
      msg_q.push_back(CHAR_HASH);
      msg_q.push_back(CHAR_BAR);
      for (k = $urandom_range(5); k > 0; k--) msg_q.push_back(tail_byte());
    end
  endtask

  task automatic test_literal_extremes();
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_color_markup();
    settle();
    write_default(24'h123456);
    // uppercase and non-hex digits, then restore
    send_text("#|A0f9Gzk|#m", 1'b1);
  endtask

  task automatic test_stray_markers();
    send_text("#x|", 1'b1);
    // markup only: bare end marker
    send_text("|#", 1'b1);
  endtask

  task automatic test_end_flush();
    send_text("#|#q", 1'b1);
    send_text("#", 1'b1);
    send_text("#|", 1'b1);
  endtask

  task automatic test_default_mid_message();
    settle();
    write_default(24'h0000FF);
    send_text("x#|00ff00a", 1'b0);
    settle();
    write_default(24'hABCDEF);
    send_text("b|#c", 1'b1);
  endtask

  task automatic test_random_phase(input int idle, input int stall, input logic [23:0] rgb);
    int stop_at;
    int i;
    settle();
    send_idle_pct = idle;
    stall_pct     = stall;
    write_default(rgb);
    stop_at = n_items + PHASE_ITEMS;
    while (n_items < stop_at) begin
      build_message();
      for (i = 0; i < msg_q.size(); i++) send_item(msg_q[i], i == msg_q.size() - 1);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  // scoreboard and receiver backpressure
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (glyph_q.size() == 0) begin
        $error("unexpected request: out_char %0h", out_item_o.out_char);
        n_errors++;
      end else begin
        want_glyph = glyph_q.pop_front();
        check_field("out_char", want_glyph.out_char, out_item_o.out_char);
        check_field("red", want_glyph.red, out_item_o.red);
        check_field("green", want_glyph.green, out_item_o.green);
        check_field("blue", want_glyph.blue, out_item_o.blue);
        check_field("char_valid", 8'(want_glyph.char_valid), 8'(out_item_o.char_valid));
        check_field("out_last", 8'(want_glyph.out_last), 8'(out_item_o.out_last));
        n_glyphs++;
      end
    end
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_literal_extremes();
    test_color_markup();
    test_stray_markers();
    test_end_flush();
    test_default_mid_message();
    test_random_phase(0, 0, 24'h000000);
    test_random_phase(74, 0, 24'hFFFFFF);
    test_random_phase(0, 74, $urandom_range(24'hFFFFFF));
    test_random_phase(6, 6, $urandom_range(24'hFFFFFF));
    settle();

    if (glyph_q.size() != 0) begin
      $error("%0d expected requests never arrived", glyph_q.size());
      n_errors++;
    end
    $display("Sent %0d bytes in %0d messages; checked %0d results, %0d bare end markers.",
             n_items, n_msgs, n_glyphs, n_bare);
    $display("Four handshake pressure phases, %0d default color writes, %0d errors.",
             n_cfg, n_errors);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/icmp_pkg.sv
rtl/core/icmp_ctrl.sv
rtl/core/icmp_datapath.sv
rtl/core/inline_color_markup_parser_unit.sv
rtl/core/icmp_checker.sv
tb/tb_inline_color_markup_parser_unit.sv
